[design/kbio_pkg.sv]
// Shared types and constants for the keyboard and interrupt I/O port block.
package kbio_pkg;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_KEY   = 3'd3,
    CMD_POWER = 3'd4
  } cmd_t;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic       level;
    logic [2:0] key_col;
    logic [3:0] key_row;
    logic [7:0] write_value;
    logic [7:0] port;
    cmd_t       command;
  } item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic       power_off;
    logic       interrupt_request;
    logic [7:0] read_data;
  } result_t;

  // Copies of the port bytes that the scan, select and tick logic look at.
  typedef struct packed {
    logic [7:0] scan_sel;
    logic [7:0] control;
    logic [7:0] irq_enable;
  } port_regs_t;

  localparam int         ItemWidth    = $bits(item_t);
  localparam int         ResultWidth  = $bits(result_t);
  localparam int         InDataWidth  = ((ItemWidth + 7) / 8) * 8;
  localparam int         OutDataWidth = ((ResultWidth + 7) / 8) * 8;

  localparam logic [7:0] STATUS_BASE  = 8'hE0;
  localparam logic [7:0] IRQ_SECOND   = 8'h10;
  localparam logic [7:0] IRQ_KEYBOARD = 8'h02;
  localparam logic [7:0] ROW_IDLE     = 8'hFF;
  localparam logic [1:0] CONTROL_SEL  = 2'h3;
  localparam int         SEL_WIDTH    = 10;

endpackage

[design/kbio_port_store.sv]
// Port byte memory with per-entry valid bits, plus copies of the special port bytes.
module kbio_port_store #(
  parameter int SCAN_PORT    = 1,
  parameter int CONTROL_PORT = 2,
  parameter int IRQ_PORT     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic                  wr_en,
  input  logic [7:0]            addr,
  input  logic [7:0]            wdata,
  output logic [7:0]            rd_data,
  output kbio_pkg::port_regs_t  port_regs
);
  import kbio_pkg::*;

  localparam logic [7:0] ScanAddr    = 8'(SCAN_PORT);
  localparam logic [7:0] ControlAddr = 8'(CONTROL_PORT);
  localparam logic [7:0] IrqAddr     = 8'(IRQ_PORT);

  logic [7:0]   mem [256];
  logic [255:0] valid;
  logic [7:0]   mem_q;
  logic         hit_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      mem_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      hit_q     <= 1'b0;
      port_regs <= '0;
    end else begin
      if (wr_en) begin
        valid[addr] <= 1'b1;
        if (addr == ScanAddr)    port_regs.scan_sel   <= wdata;
        if (addr == ControlAddr) port_regs.control    <= wdata;
        if (addr == IrqAddr)     port_regs.irq_enable <= wdata;
      end
      if (rd_en) begin
        hit_q <= valid[addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = mem_q & {8{hit_q}};

endmodule

[design/kbio_exec.sv]
// Keyboard matrix, interrupt status, tick counter and per-item result logic.
module kbio_exec #(
  parameter int KEY_ROW_COUNT = 10,
  parameter int SCAN_PORT     = 1,
  parameter int IRQ_PORT      = 3,
  parameter int STATUS_PORT   = 9,
  parameter int SHUTDOWN_PORT = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  kbio_pkg::item_t       item,
  input  kbio_pkg::port_regs_t  port_regs,
  input  logic [7:0]            mem_data,
  output kbio_pkg::result_t     result
);
  import kbio_pkg::*;

  localparam logic [7:0] ScanAddr     = 8'(SCAN_PORT);
  localparam logic [7:0] IrqAddr      = 8'(IRQ_PORT);
  localparam logic [7:0] StatusAddr   = 8'(STATUS_PORT);
  localparam logic [7:0] ShutdownAddr = 8'(SHUTDOWN_PORT);

  logic [7:0] key_rows      [KEY_ROW_COUNT];
  logic [7:0] key_rows_next [KEY_ROW_COUNT];
  logic [7:0] interrupt_status;
  logic [7:0] interrupt_status_next;
  logic [5:0] second_ticks;
  logic [5:0] second_ticks_next;
  logic       button_held;
  logic       button_held_next;

  logic [15:0] sel;
  logic [7:0]  scan;
  logic [7:0]  col_bit;
  logic        second_due;

  always_comb begin
    sel  = {{(16 - SEL_WIDTH){1'b0}}, port_regs.control[1:0] & CONTROL_SEL,
            port_regs.scan_sel};
    scan = ROW_IDLE;
    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
      if (!sel[r]) scan = scan & key_rows[r];
    end
  end

  assign col_bit = 8'(1) << item.key_col;

  always_comb begin
    result                = '0;
    interrupt_status_next = interrupt_status;
    second_ticks_next     = second_ticks;
    button_held_next      = button_held;
    second_due            = 1'b0;
    for (int r = 0; r < KEY_ROW_COUNT; r++) begin
      key_rows_next[r] = key_rows[r];
    end
    case (item.command)
      CMD_READ: begin
        if (item.port == ScanAddr) begin
          result.read_data = scan;
        end else if (item.port == IrqAddr) begin
          result.read_data = interrupt_status;
        end else if (item.port == StatusAddr) begin
          result.read_data = STATUS_BASE | (button_held ? 8'h00 : IRQ_SECOND);
        end else begin
          result.read_data = mem_data;
        end
      end
      CMD_WRITE: begin
        if (item.port == IrqAddr) begin
          interrupt_status_next = interrupt_status & item.write_value;
        end
        if (item.port == ShutdownAddr && item.write_value[0]) begin
          result.power_off = 1'b1;
        end
      end
      CMD_TICK: begin
        second_ticks_next = second_ticks + 6'd1;
        second_due = (second_ticks_next == 6'd0)
                     && ((port_regs.irq_enable & IRQ_SECOND) != 8'h00)
                     && ((interrupt_status & IRQ_SECOND) == 8'h00);
        if (second_due) begin
          interrupt_status_next    = interrupt_status | IRQ_SECOND;
          result.interrupt_request = 1'b1;
        end else if (((port_regs.irq_enable & IRQ_KEYBOARD) != 8'h00)
                     && ((interrupt_status & IRQ_KEYBOARD) == 8'h00)) begin
          interrupt_status_next    = interrupt_status | IRQ_KEYBOARD;
          result.interrupt_request = 1'b1;
        end
      end
      CMD_KEY: begin
        // rows beyond the matrix match no entry and are dropped
        for (int r = 0; r < KEY_ROW_COUNT; r++) begin
          if (item.key_row == 4'(r)) begin
            key_rows_next[r] = item.level ? (key_rows[r] & ~col_bit)
                                          : (key_rows[r] | col_bit);
          end
        end
      end
      CMD_POWER: begin
        button_held_next = item.level;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_status <= '0;
      second_ticks     <= '0;
      button_held      <= 1'b0;
      for (int r = 0; r < KEY_ROW_COUNT; r++) begin
        key_rows[r] <= ROW_IDLE;
      end
    end else if (advance) begin
      interrupt_status <= interrupt_status_next;
      second_ticks     <= second_ticks_next;
      button_held      <= button_held_next;
      for (int r = 0; r < KEY_ROW_COUNT; r++) begin
        key_rows[r] <= key_rows_next[r];
      end
    end
  end

endmodule

[design/keyboard_interrupt_io_controller.sv]
// Top level: input stage, port store, execution logic and result register.
// Items pass the item register, then the output register. One item per cycle
// while m_tready does not stall; the port byte memory is read at accept and its
// registered output meets the item in the execution stage.
// Reset: clears pipeline valids, interrupt status, tick count and button state,
// sets all key rows to released and marks all 256 port bytes as zero.
module keyboard_interrupt_io_controller #(
  parameter int KEY_ROW_COUNT = 10,
  parameter int SCAN_PORT     = 1,
  parameter int CONTROL_PORT  = 2,
  parameter int IRQ_PORT      = 3,
  parameter int STATUS_PORT   = 9,
  parameter int SHUTDOWN_PORT = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // command[2:0], port[10:3], write_value[18:11], key_row[22:19],
  // key_col[25:23], level[26], zero fill above
  input  logic [kbio_pkg::InDataWidth-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // read_data[7:0], interrupt_request[8], power_off[9], zero fill above
  output logic [kbio_pkg::OutDataWidth-1:0]   m_tdata
);
  import kbio_pkg::*;

  item_t      in_item;
  item_t      item;
  logic       item_valid;
  logic       accept;
  logic       out_load;
  logic       advance;
  result_t    result;
  result_t    out_result;
  port_regs_t port_regs;
  logic [7:0] mem_data;

  assign in_item  = item_t'(s_tdata[ItemWidth-1:0]);
  assign out_load = !m_tvalid || m_tready;
  assign advance  = item_valid && out_load;
  assign s_tready = !item_valid || out_load;
  assign accept   = s_tvalid && s_tready;

  kbio_port_store #(
    .SCAN_PORT    (SCAN_PORT),
    .CONTROL_PORT (CONTROL_PORT),
    .IRQ_PORT     (IRQ_PORT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .wr_en     (accept && in_item.command == CMD_WRITE),
    .addr      (in_item.port),
    .wdata     (in_item.write_value),
    .rd_data   (mem_data),
    .port_regs (port_regs)
  );

  kbio_exec #(
    .KEY_ROW_COUNT (KEY_ROW_COUNT),
    .SCAN_PORT     (SCAN_PORT),
    .IRQ_PORT      (IRQ_PORT),
    .STATUS_PORT   (STATUS_PORT),
    .SHUTDOWN_PORT (SHUTDOWN_PORT)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .port_regs (port_regs),
    .mem_data  (mem_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_tready) item_valid <= s_tvalid;
      if (out_load) m_tvalid   <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept)  item       <= in_item;
    if (advance) out_result <= result;
  end

  assign m_tdata = {{(OutDataWidth - ResultWidth){1'b0}}, out_result};

endmodule
